// ----- src/tcw_pkg.sv -----
// Shared constants and types for the text console character writer.
package tcw_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;

    localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h07;

    localparam logic [BYTE_W-1:0] CODE_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CODE_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CODE_BS = 8'h08;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // write port of the cell store: byte lanes with their own enables
    typedef struct packed {
        logic              char_en;
        logic              attr_en;
        logic [BYTE_W-1:0] char_data;
        logic [BYTE_W-1:0] attr_data;
    } tcw_wr_t;

endpackage

// ----- src/tcw_cmd_if.sv -----
// Command channel: put or read transactions into the console.
interface tcw_cmd_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [tcw_pkg::BYTE_W-1:0]   char_code;
    logic [tcw_pkg::INDEX_W-1:0]  cell_index;

    modport source (output valid, output op, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input op, input char_code, input cell_index,
                    output ready);
endinterface

// ----- src/tcw_rsp_if.sv -----
// Response channel: one result per command transaction.
interface tcw_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::CURSOR_W-1:0] cursor_pos;
    logic [tcw_pkg::BYTE_W-1:0]   cell_char;
    logic [tcw_pkg::BYTE_W-1:0]   cell_attr;
    logic                         scrolled;

    modport source (output valid, output cursor_pos, output cell_char, output cell_attr,
                    output scrolled, input ready);
    modport sink   (input valid, input cursor_pos, input cell_char, input cell_attr,
                    input scrolled, output ready);
endinterface

// ----- src/tcw_cell_store.sv -----
// Character and attribute memories: one write port, one registered read port.
module tcw_cell_store #(
    parameter int DEPTH = tcw_pkg::DEFAULT_COLUMNS * tcw_pkg::DEFAULT_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic [AW-1:0]              wr_addr,
    input  tcw_pkg::tcw_wr_t           wr,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [tcw_pkg::BYTE_W-1:0] rd_char,
    output logic [tcw_pkg::BYTE_W-1:0] rd_attr
);

    logic [tcw_pkg::BYTE_W-1:0] char_mem [DEPTH];
    logic [tcw_pkg::BYTE_W-1:0] attr_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.char_en)
        begin
            char_mem[wr_addr] <= wr.char_data;
        end
        if (wr.attr_en)
        begin
            attr_mem[wr_addr] <= wr.attr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_char <= char_mem[rd_addr];
            rd_attr <= attr_mem[rd_addr];
        end
    end

endmodule

// ----- src/text_console_char_writer.sv -----
// Text console engine top level: cursor control, scroll sweep and result register.
// Put or read: the accepted transaction passes through the hold state into the
//   output register, which waits for an earlier result to be taken; the next
//   transaction is accepted only after the result-hold state, back in idle.
// Scrolling put: the sweep copies one cell per cycle through the memory port.
// Reset: a clearing pass over all cells writes blank cells; commands wait for
//   it, configuration writes are taken throughout.
module text_console_char_writer #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tcw_cmd_if.sink                    cmd,
    tcw_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [tcw_pkg::BYTE_W-1:0] cfg_wdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    // wide enough for both the cell address and the 11-bit port fields
    localparam int IW    = (AW > tcw_pkg::INDEX_W) ? AW : tcw_pkg::INDEX_W;

    localparam logic [AW-1:0] LAST_BASE = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,   // post-reset blanking pass
        ST_IDLE,    // ready for a command
        ST_SCROLL,  // moving rows up one cell per cycle
        ST_HOLD     // result waiting for the output register
    } state_t;

    state_t                     state_reg;
    logic [AW-1:0]              cursor_reg;
    logic [CW-1:0]              col_reg;
    logic [AW-1:0]              rowbase_reg;    // address of column 0 of cursor row
    logic [AW-1:0]              sweep_reg;
    logic [tcw_pkg::BYTE_W-1:0] fill_attr_reg;

    // scroll write stage: registered, follows the sweep read in the next cycle
    logic                       st_valid_reg;
    logic [AW-1:0]              st_addr_reg;
    logic                       st_blank_reg;

    logic                       res_hit_reg;    // read inside the screen
    logic                       res_scr_reg;

    logic                       out_valid_reg;
    logic [tcw_pkg::CURSOR_W-1:0] out_cursor_reg;
    logic [tcw_pkg::BYTE_W-1:0] out_char_reg;
    logic [tcw_pkg::BYTE_W-1:0] out_attr_reg;
    logic                       out_scr_reg;

    logic [AW-1:0]              cursor_next;
    logic [CW-1:0]              col_next;
    logic [AW-1:0]              rowbase_next;
    logic                       scroll_next;

    logic                       accept;
    logic                       is_read;
    logic                       last_row;
    logic                       idx_hit;
    logic [IW-1:0]              idx_wide;
    logic [IW-1:0]              cur_wide;
    logic                       out_free;

    logic [AW-1:0]              wr_addr;
    tcw_pkg::tcw_wr_t           wr;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [tcw_pkg::BYTE_W-1:0] rd_char;
    logic [tcw_pkg::BYTE_W-1:0] rd_attr;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign is_read   = (cmd.op == tcw_pkg::OP_READ);
    assign last_row  = (rowbase_reg == LAST_BASE);
    assign idx_hit   = (32'(cmd.cell_index) < 32'(CELLS));
    assign idx_wide  = IW'(cmd.cell_index);
    assign cur_wide  = IW'(cursor_reg);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid      = out_valid_reg;
    assign rsp.cursor_pos = out_cursor_reg;
    assign rsp.cell_char  = out_char_reg;
    assign rsp.cell_attr  = out_attr_reg;
    assign rsp.scrolled   = out_scr_reg;

    // Cursor motion for a put. Row and column are tracked apart so that no
    // division by the row length is needed.
    always_comb
    begin
        cursor_next  = cursor_reg;
        col_next     = col_reg;
        rowbase_next = rowbase_reg;
        scroll_next  = 1'b0;
        case (cmd.char_code)
            tcw_pkg::CODE_CR:
            begin
                cursor_next = rowbase_reg;
                col_next    = '0;
            end
            tcw_pkg::CODE_LF:
            begin
                col_next = '0;
                if (last_row)
                begin
                    scroll_next = 1'b1;
                    cursor_next = LAST_BASE;
                end
                else
                begin
                    rowbase_next = rowbase_reg + ROW_STEP;
                    cursor_next  = rowbase_reg + ROW_STEP;
                end
            end
            tcw_pkg::CODE_BS:
            begin
                // stays put at the home cell
                if (cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - 1'b1;
                    if (col_reg == '0)
                    begin
                        col_next     = COL_LAST;
                        rowbase_next = rowbase_reg - ROW_STEP;
                    end
                    else
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                if (col_reg == COL_LAST)
                begin
                    col_next = '0;
                    if (last_row)
                    begin
                        // wrap off the bottom: screen moves up, cursor to last row
                        scroll_next = 1'b1;
                        cursor_next = LAST_BASE;
                    end
                    else
                    begin
                        rowbase_next = rowbase_reg + ROW_STEP;
                        cursor_next  = cursor_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next    = col_reg + 1'b1;
                    cursor_next = cursor_reg + 1'b1;
                end
            end
        endcase
    end

    // Memory write port. Sources never overlap: clearing, the scroll write stage
    // and an accepted put each own the port in turn.
    always_comb
    begin
        wr_addr      = cursor_reg;
        wr.char_en   = 1'b0;
        wr.attr_en   = 1'b0;
        wr.char_data = tcw_pkg::BLANK_CHAR;
        wr.attr_data = fill_attr_reg;
        if (state_reg == ST_CLEAR)
        begin
            wr_addr      = sweep_reg;
            wr.char_en   = 1'b1;
            wr.attr_en   = 1'b1;
            wr.attr_data = tcw_pkg::RESET_ATTR;
        end
        else if (st_valid_reg)
        begin
            wr_addr    = st_addr_reg;
            wr.char_en = 1'b1;
            wr.attr_en = 1'b1;
            if (!st_blank_reg)
            begin
                wr.char_data = rd_char;
                wr.attr_data = rd_attr;
            end
        end
        else if (accept && !is_read)
        begin
            if (cmd.char_code == tcw_pkg::CODE_BS)
            begin
                wr.char_en = 1'b1;
                wr.attr_en = 1'b1;
            end
            else if (cmd.char_code != tcw_pkg::CODE_CR && cmd.char_code != tcw_pkg::CODE_LF)
            begin
                // ordinary byte: the cell keeps its attribute
                wr.char_en   = 1'b1;
                wr.char_data = cmd.char_code;
            end
        end
    end

    // Read port: command reads, or the source row during a scroll.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = sweep_reg + ROW_STEP;
        if (state_reg == ST_SCROLL)
        begin
            rd_en = (sweep_reg < LAST_BASE);
        end
        else if (accept && is_read)
        begin
            rd_en   = idx_hit;
            rd_addr = idx_wide[AW-1:0];
        end
    end

    tcw_cell_store #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_addr (wr_addr),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_char (rd_char),
        .rd_attr (rd_attr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cursor_reg     <= '0;
            col_reg        <= '0;
            rowbase_reg    <= '0;
            sweep_reg      <= '0;
            fill_attr_reg  <= tcw_pkg::RESET_ATTR;
            st_valid_reg   <= 1'b0;
            st_addr_reg    <= '0;
            st_blank_reg   <= 1'b0;
            res_hit_reg    <= 1'b0;
            res_scr_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_cursor_reg <= '0;
            out_char_reg   <= '0;
            out_attr_reg   <= '0;
            out_scr_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fill_attr_reg <= cfg_wdata;
            end

            // write stage follows each sweep cycle
            st_valid_reg <= (state_reg == ST_SCROLL);

            // in the hold state the output register is reloaded instead
            if (out_valid_reg && rsp.ready && state_reg != ST_HOLD)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    if (sweep_reg == LAST_ADDR)
                    begin
                        sweep_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_read)
                        begin
                            res_hit_reg <= idx_hit;
                            res_scr_reg <= 1'b0;
                            state_reg   <= ST_HOLD;
                        end
                        else
                        begin
                            cursor_reg  <= cursor_next;
                            col_reg     <= col_next;
                            rowbase_reg <= rowbase_next;
                            res_hit_reg <= 1'b0;
                            res_scr_reg <= scroll_next;
                            sweep_reg   <= '0;
                            state_reg   <= scroll_next ? ST_SCROLL : ST_HOLD;
                        end
                    end
                end
                ST_SCROLL:
                begin
                    // cell k takes cell k+COLUMNS; the last row turns blank
                    st_addr_reg  <= sweep_reg;
                    st_blank_reg <= (sweep_reg >= LAST_BASE);
                    if (sweep_reg == LAST_ADDR)
                    begin
                        sweep_reg <= '0;
                        state_reg <= ST_HOLD;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_cursor_reg <= cur_wide[tcw_pkg::CURSOR_W-1:0];
                        out_char_reg   <= res_hit_reg ? rd_char : '0;
                        out_attr_reg   <= res_hit_reg ? rd_attr : '0;
                        out_scr_reg    <= res_scr_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
